@@ design/lcdexp_pkg.sv @@
// Package for the character LCD expander sequencer: command codes, LCD
// constants, the queue descriptor type and the init nibble table.
// No dependencies.
`timescale 1ns / 1ps

package lcdexp_pkg;

  // Command codes carried in the input kind field
  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_TEXT = 2'd1,
    CMD_POS  = 2'd2,
    CMD_RAW  = 2'd3
  } cmd_e;

  // Segment codes of a non-init run (index bits [2:1] in the back end)
  localparam logic [1:0] SEG_MAIN  = 2'd0;
  localparam logic [1:0] SEG_LINE2 = 2'd1;
  localparam logic [1:0] SEG_DISP  = 2'd2;

  // LCD command bytes
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LCD_LINE1_OFS = 8'h40;
  localparam logic [7:0] LCD_LINE2_CMD = 8'hC0;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0F;

  // Expander bit positions and init length
  localparam logic       EXP_BACKLIGHT = 1'b1;
  localparam logic       EXP_RW        = 1'b0;
  localparam logic [3:0] INIT_LAST_NIB = 4'd13;
  localparam logic [6:0] SLAVE_ADDR_RST = 7'h27;

  // Defaults handed to the top level parameters
  localparam int LINE_LENGTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // One classified request as it waits for the back end
  typedef struct packed {
    logic       init;     // run the init sequence
    logic       rs;       // register select of the main byte
    logic [7:0] data;     // main byte
    logic       line2;    // append the second-line command
    logic       disp_on;  // append the display-on command
  } desc_t;

  // Init sequence: 3,3,3,2 then 0x28,0x08,0x01,0x0F,0x01 as nibbles
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    case (idx)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5, 4'd7:       nib = 4'h8;
      4'd9, 4'd13:      nib = 4'h1;
      4'd11:            nib = 4'hF;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

@@ design/lcdexp_front.sv @@
// Front end: accepts requests, tracks the text column and builds the
// descriptor for the back end. Depends on lcdexp_pkg.
`timescale 1ns / 1ps

module lcdexp_front #(
  parameter int LINE_LENGTH = lcdexp_pkg::LINE_LENGTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  lcdexp_pkg::cmd_e    cmd_i,
  input  logic [7:0]          value_i,
  input  logic                line_i,
  input  logic                first_i,
  input  logic                last_i,
  output lcdexp_pkg::desc_t   desc_o
);

  localparam int CW = $clog2(LINE_LENGTH + 1);
  localparam logic [CW-1:0] COL_WRAP = CW'(LINE_LENGTH - 1);
  localparam logic [CW-1:0] COL_MAX  = CW'(LINE_LENGTH);

  logic [CW-1:0] col_q, col_d, col_cur;

  // Column seen by this character, first mark restarts the count
  assign col_cur = first_i ? '0 : col_q;

  // Classify the request
  always_comb begin
    desc_o         = '0;
    col_d          = col_q;
    case (cmd_i)
      lcdexp_pkg::CMD_INIT: begin
        desc_o.init = 1'b1;
      end
      lcdexp_pkg::CMD_TEXT: begin
        desc_o.rs      = 1'b1;
        desc_o.data    = value_i;
        desc_o.line2   = (col_cur == COL_WRAP);
        desc_o.disp_on = last_i;
        col_d          = (col_cur < COL_MAX) ? col_cur + CW'(1) : col_cur;
      end
      lcdexp_pkg::CMD_POS: begin
        desc_o.data = lcdexp_pkg::LCD_SET_DDRAM | value_i |
                      (line_i ? lcdexp_pkg::LCD_LINE1_OFS : 8'h00);
      end
      default: begin
        desc_o.data = value_i;
      end
    endcase
  end

  // Column counter, saturates at the line length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
    end
  end

endmodule

@@ design/lcdexp_fifo.sv @@
// Short descriptor queue between front and back end.
// Depends on lcdexp_pkg.
`timescale 1ns / 1ps

module lcdexp_fifo #(
  parameter int DEPTH = lcdexp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lcdexp_pkg::desc_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output lcdexp_pkg::desc_t rdata_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  lcdexp_pkg::desc_t mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  // Storage, payload only
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

@@ design/lcdexp_back.sv @@
// Back end: walks the nibbles of one descriptor and emits three expander
// bytes per nibble into the output register. Depends on lcdexp_pkg.
`timescale 1ns / 1ps

module lcdexp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  lcdexp_pkg::desc_t q_desc_i,
  output logic              q_pop_o,
  input  logic [6:0]        slave_addr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [6:0]        out_addr_o,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);

  lcdexp_pkg::desc_t desc_q;
  logic       busy_q, busy_d;
  logic [3:0] idx_q, idx_d;
  logic [1:0] ph_q, ph_d;
  logic       ov_q;
  logic [6:0] addr_q;
  logic [7:0] byte_q;
  logic       last_q;

  logic       adv, step, nib_last, run_last;
  logic [1:0] seg, seg_next;
  logic       seg_none;
  logic [7:0] cur_byte, exp_byte;
  logic [3:0] nib;
  logic       rs;

  assign adv      = !ov_q || out_ready_i;
  assign step     = busy_q && adv;
  assign seg      = idx_q[2:1];

  // Segment after the current one in a non-init run
  always_comb begin
    seg_none = 1'b0;
    seg_next = lcdexp_pkg::SEG_DISP;
    case (seg)
      lcdexp_pkg::SEG_MAIN: begin
        if (desc_q.line2) seg_next = lcdexp_pkg::SEG_LINE2;
        else if (!desc_q.disp_on) seg_none = 1'b1;
      end
      lcdexp_pkg::SEG_LINE2: begin
        if (!desc_q.disp_on) seg_none = 1'b1;
      end
      default: seg_none = 1'b1;
    endcase
  end

  // Current nibble and expander byte
  always_comb begin
    case (seg)
      lcdexp_pkg::SEG_MAIN:  cur_byte = desc_q.data;
      lcdexp_pkg::SEG_LINE2: cur_byte = lcdexp_pkg::LCD_LINE2_CMD;
      default:               cur_byte = lcdexp_pkg::LCD_DISP_ON;
    endcase
    if (desc_q.init) begin
      nib      = lcdexp_pkg::init_nibble(idx_q);
      rs       = 1'b0;
      nib_last = (idx_q == lcdexp_pkg::INIT_LAST_NIB);
    end else begin
      nib      = idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
      rs       = (seg == lcdexp_pkg::SEG_MAIN) && desc_q.rs;
      nib_last = idx_q[0] && seg_none;
    end
    exp_byte = {nib, lcdexp_pkg::EXP_BACKLIGHT, (ph_q == 2'd1),
                lcdexp_pkg::EXP_RW, rs};
  end

  assign run_last = nib_last && (ph_q == 2'd2);
  assign q_pop_o  = q_valid_i && (!busy_q || (step && run_last));

  // Phase and nibble counters
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    ph_d   = ph_q;
    if (step) begin
      if (ph_q != 2'd2) begin
        ph_d = ph_q + 2'd1;
      end else begin
        ph_d = 2'd0;
        if (run_last) begin
          busy_d = 1'b0;
        end else if (desc_q.init || !idx_q[0]) begin
          idx_d = idx_q + 4'd1;
        end else begin
          idx_d = {1'b0, seg_next, 1'b0};
        end
      end
    end
    if (q_pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
      ph_d   = 2'd0;
    end
  end

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ph_q   <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ph_q   <= ph_d;
      if (adv) begin
        ov_q <= busy_q;
      end
    end
  end

  // Descriptor and output payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      desc_q <= q_desc_i;
    end
    if (step) begin
      addr_q <= slave_addr_i;
      byte_q <= exp_byte;
      last_q <= run_last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_addr_o  = addr_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

@@ design/char_lcd_i2c_expander_sequencer_core.sv @@
// Top level of the character LCD sequencer for an I2C port expander.
// Depends on lcdexp_pkg, lcdexp_front, lcdexp_fifo and lcdexp_back.
//
//   Channel   Direction  Handshake          Payload
//   s_axis    in         tvalid/tready      tdata, tuser, tlast (request)
//   m_axis    out        tvalid/tready      tdata, tlast (expander byte)
//   cfg       in         cfg_we_i           cfg_wdata_i (slave address)
//
// One expander byte leaves per cycle while the sink is ready: a text
// character is 6, 12 or 18 expander bytes, a command 6, init 42, as
// the back-end nibble sequencer emits them; the front takes a request in
// any cycle the descriptor queue has room, so runs follow with no gap.
// Reset clears the queue, the column counter and the sequencer, and sets
// the slave address to 0x27. A stalled sink holds the output register and
// the sequencer; requests keep queuing until the queue fills.
`timescale 1ns / 1ps

module char_lcd_i2c_expander_sequencer_core #(
  parameter int LINE_LENGTH = lcdexp_pkg::LINE_LENGTH_DEF,
  parameter int QUEUE_DEPTH = lcdexp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] value, [8] line, rest zero
  input  logic [2:0]  s_axis_tuser,   // [1:0] cmd, [2] first_of_text
  input  logic        s_axis_tlast,   // last_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] device_address, [14:7] expander_byte
  output logic        m_axis_tlast    // last_of_run
);

  logic [6:0]        slave_addr_q;
  logic              s_accept, q_full, q_valid, q_pop;
  lcdexp_pkg::desc_t front_desc, q_desc;
  logic [6:0]        out_addr;
  logic [7:0]        out_byte;

  assign s_axis_tready = !q_full;
  assign s_accept      = s_axis_tvalid && !q_full;

  // Slave address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= lcdexp_pkg::SLAVE_ADDR_RST;
    end else if (cfg_we_i) begin
      slave_addr_q <= cfg_wdata_i;
    end
  end

  lcdexp_front #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_accept),
    .cmd_i    (lcdexp_pkg::cmd_e'(s_axis_tuser[1:0])),
    .value_i  (s_axis_tdata[7:0]),
    .line_i   (s_axis_tdata[8]),
    .first_i  (s_axis_tuser[2]),
    .last_i   (s_axis_tlast),
    .desc_o   (front_desc)
  );

  lcdexp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_accept),
    .wdata_i (front_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_desc)
  );

  lcdexp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_desc_i     (q_desc),
    .q_pop_o      (q_pop),
    .slave_addr_i (slave_addr_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_byte_o   (out_byte),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_byte, out_addr};

endmodule

@@ tb/sv/char_lcd_i2c_expander_sequencer_core_tb.sv @@
// Self-checking testbench for char_lcd_i2c_expander_sequencer_core.
// Predicts the expander byte stream of every request and checks it on the
// output stream. Depends on lcdexp_pkg and the core.
`timescale 1ns / 1ps

module char_lcd_i2c_expander_sequencer_core_tb;

  localparam int TEXT_LINE_LENGTH = 16;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int SETTLE_CYCLES    = 16;
  localparam int MAX_PRINTED      = 40;

  // LCD init bytes and nibbles, expander enable strobe
  localparam logic [3:0] INIT_WAKE_NIB = 4'h3;
  localparam logic [3:0] INIT_4BIT_NIB = 4'h2;
  localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
  localparam logic [7:0] LCD_DISP_OFF  = 8'h08;
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic       EXP_EN_ON     = 1'b1;
  localparam logic       EXP_EN_OFF    = 1'b0;

  // One expected transaction on the output stream
  typedef struct packed {
    logic [6:0] addr;
    logic [7:0] xbyte;
    logic       last;
  } exp_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] value, [8] line, rest zero
  logic [2:0]  s_axis_tuser = '0;   // [1:0] cmd, [2] first_of_text
  logic        s_axis_tlast = 1'b0; // last_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [6:0] device_address, [14:7] expander_byte
  logic        m_axis_tlast;        // last_of_run

  // Predictor state and expected byte store
  exp_byte_t   pending_bytes[$];
  logic [6:0]  exp_address = lcdexp_pkg::SLAVE_ADDR_RST;
  logic [4:0]  text_column = '0;

  int error_count = 0;
  int requests_sent = 0;
  int bytes_checked = 0;
  int address_writes = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;

  char_lcd_i2c_expander_sequencer_core #(
    .LINE_LENGTH(TEXT_LINE_LENGTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Predictor: one nibble is three expander bytes, strobe in the middle
  task automatic queue_nibble(input logic [3:0] nib, input logic rs);
    logic [7:0] base;
    logic [7:0] strobe;
    base   = {nib, lcdexp_pkg::EXP_BACKLIGHT, EXP_EN_OFF, lcdexp_pkg::EXP_RW, rs};
    strobe = {nib, lcdexp_pkg::EXP_BACKLIGHT, EXP_EN_ON, lcdexp_pkg::EXP_RW, rs};
    pending_bytes.push_back({exp_address, base, 1'b0});
    pending_bytes.push_back({exp_address, strobe, 1'b0});
    pending_bytes.push_back({exp_address, base, 1'b0});
  endtask

  task automatic queue_lcd_byte(input logic [7:0] b, input logic rs);
    queue_nibble(b[7:4], rs);
    queue_nibble(b[3:0], rs);
  endtask

  task automatic predict_request(input lcdexp_pkg::cmd_e cmd, input logic [7:0] value,
                                 input logic line, input logic first, input logic last);
    exp_byte_t tail;
    case (cmd)
      lcdexp_pkg::CMD_INIT: begin
        queue_nibble(INIT_WAKE_NIB, 1'b0);
        queue_nibble(INIT_WAKE_NIB, 1'b0);
        queue_nibble(INIT_WAKE_NIB, 1'b0);
        queue_nibble(INIT_4BIT_NIB, 1'b0);
        queue_lcd_byte(LCD_FUNC_SET, 1'b0);
        queue_lcd_byte(LCD_DISP_OFF, 1'b0);
        queue_lcd_byte(LCD_CLEAR, 1'b0);
        queue_lcd_byte(lcdexp_pkg::LCD_DISP_ON, 1'b0);
        queue_lcd_byte(LCD_CLEAR, 1'b0);
      end
      lcdexp_pkg::CMD_TEXT: begin
        if (first) text_column = '0;
        queue_lcd_byte(value, 1'b1);
        // jump to the second line after the last column of the first
        if (text_column == 5'(TEXT_LINE_LENGTH - 1))
          queue_lcd_byte(lcdexp_pkg::LCD_LINE2_CMD, 1'b0);
        if (text_column < 5'(TEXT_LINE_LENGTH)) text_column = text_column + 5'd1;
        if (last) queue_lcd_byte(lcdexp_pkg::LCD_DISP_ON, 1'b0);
      end
      lcdexp_pkg::CMD_POS: begin
        queue_lcd_byte(lcdexp_pkg::LCD_SET_DDRAM | value |
                       (line ? lcdexp_pkg::LCD_LINE1_OFS : 8'h00), 1'b0);
      end
      default: begin
        queue_lcd_byte(value, 1'b0);
      end
    endcase
    tail = pending_bytes.pop_back();
    tail.last = 1'b1;
    pending_bytes.push_back(tail);
  endtask

  // Monitor: sampled at the falling edge, where both streams are stable
  always @(negedge clk_i) begin
    exp_byte_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        predict_request(lcdexp_pkg::cmd_e'(s_axis_tuser[1:0]), s_axis_tdata[7:0],
                        s_axis_tdata[8], s_axis_tuser[2], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_checked++;
        if (pending_bytes.size() == 0) begin
          report_mismatch("output transaction with nothing expected", m_axis_tdata, 0);
        end else begin
          want = pending_bytes.pop_front();
          if (m_axis_tdata[6:0] !== want.addr)
            report_mismatch("device_address", m_axis_tdata[6:0], want.addr);
          if (m_axis_tdata[14:7] !== want.xbyte)
            report_mismatch("expander_byte", m_axis_tdata[14:7], want.xbyte);
          if (m_axis_tlast !== want.last)
            report_mismatch("last_of_run", m_axis_tlast, want.last);
        end
      end
    end
  end

  // Sink ready: random idling, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      stall_left <= HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one request and hold it until the core takes it
  task automatic send_request(input lcdexp_pkg::cmd_e cmd, input logic [7:0] value,
                              input logic line, input logic first, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, line, value};
    s_axis_tuser  <= {first, cmd};
    s_axis_tlast  <= last;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    requests_sent++;
  endtask

  // Stop offering and let every expected transaction arrive
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_slave_address(input logic [6:0] addr);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    exp_address = addr;
    address_writes++;
    @(posedge clk_i);
  endtask

  // Init sequence with the address left at its reset value
  task automatic test_init_sequence();
    send_request(lcdexp_pkg::CMD_INIT, 8'h00, 1'b0, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Raw commands and cursor positions, text flags that must be ignored
  task automatic test_command_bytes();
    set_slave_address(7'h7F);
    send_request(lcdexp_pkg::CMD_RAW, 8'h00, 1'b0, 1'b1, 1'b1);
    send_request(lcdexp_pkg::CMD_RAW, 8'hFF, 1'b1, 1'b0, 1'b0);
    send_request(lcdexp_pkg::CMD_POS, 8'h00, 1'b0, 1'b0, 1'b0);
    send_request(lcdexp_pkg::CMD_POS, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_request(lcdexp_pkg::CMD_POS, 8'h0F, 1'b1, 1'b0, 1'b0);
    wait_idle();
  endtask

  // A full line of text: second-line jump after the last column, display-on
  // at the end, a one-character text, then counting on without a first mark
  task automatic test_text_line_wrap();
    logic [7:0] ch;
    set_slave_address(7'h00);
    for (int i = 0; i < TEXT_LINE_LENGTH; i++) begin
      ch = (i == 0) ? 8'h00 : (i == TEXT_LINE_LENGTH - 1) ? 8'hFF : 8'(8'h41 + i);
      send_request(lcdexp_pkg::CMD_TEXT, ch, 1'b0, i == 0, i == TEXT_LINE_LENGTH - 1);
    end
    send_request(lcdexp_pkg::CMD_TEXT, 8'h5A, 1'b1, 1'b1, 1'b1);
    send_request(lcdexp_pkg::CMD_TEXT, 8'hA5, 1'b0, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Sink holds off while requests keep coming, so the queue fills up
  task automatic test_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    stall_requests++;
    for (int i = 0; i < 12; i++)
      send_request(lcdexp_pkg::cmd_e'((i % 3 == 0) ? lcdexp_pkg::CMD_RAW
                                                    : lcdexp_pkg::CMD_TEXT),
                   8'($urandom_range(255)), 1'b0, i == 1, i == 11);
    wait_idle();
    send_idle_pct = saved_pct;
  endtask

  // Random traffic, mostly well-formed texts with random content
  task automatic run_random_phase(input int target, input int send_pct, input int recv_pct);
    int sent;
    int pick;
    int len;
    set_slave_address(7'($urandom_range(127)));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_request(lcdexp_pkg::CMD_TEXT, 8'($urandom_range(255)),
                       1'($urandom_range(1)), i == 0, i == len - 1);
        sent += len;
      end else if (pick < 62) begin
        // text continued without a first mark
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          send_request(lcdexp_pkg::CMD_TEXT, 8'($urandom_range(255)),
                       1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)));
        sent += len;
      end else if (pick < 76) begin
        send_request(lcdexp_pkg::CMD_POS, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 90) begin
        send_request(lcdexp_pkg::CMD_RAW, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 94) begin
        send_request(lcdexp_pkg::CMD_INIT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        send_request(lcdexp_pkg::cmd_e'($urandom_range(3)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end
    end
    wait_idle();
  endtask

  // Test sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 14;
    recv_idle_pct = 69;
    test_init_sequence();
    test_command_bytes();
    test_text_line_wrap();
    test_backpressure();
    run_random_phase(42, 14, 69);
    run_random_phase(42, 69, 14);
    run_random_phase(42, 0, 0);
    $display("Sent %0d LCD requests, checked %0d expander bytes, %0d address writes.",
             requests_sent, bytes_checked, address_writes);
    $display("Covered init, text with line wrap, cursor, raw commands and a long sink stall.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
